/* design/sad_pkg.sv */
// Shared types, widths and codes for the sunrise alarm dimmer.
package sad_pkg;

	// Field widths
	localparam int unsigned NOW_W    = 32;
	localparam int unsigned HOUR_W   = 5;
	localparam int unsigned MIN_W    = 6;
	localparam int unsigned RISE_W   = 8;
	localparam int unsigned LEVEL_W  = 10;
	localparam int unsigned MODE_W   = 2;

	// Stream widths (tdata padded to whole bytes)
	localparam int unsigned S_DATA_W = 48;
	localparam int unsigned M_DATA_W = 24;

	// Ramp arithmetic: span = rise * 60 <= 15300 fits 14 bits,
	// elapsed * target fits 24 bits
	localparam int unsigned SECS_PER_MIN = 60;
	localparam int unsigned SPAN_W       = 14;
	localparam int unsigned PROD_W       = SPAN_W + LEVEL_W;

	// Level limits
	localparam int unsigned FIELD_MAX     = 1023;
	localparam int unsigned LEVEL_MAX_DEF = 1023;

	// Configuration port
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 10;

	localparam logic [CFG_IDX_W-1:0] CFG_ALARM_ENABLED = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ALARM_HOUR    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ALARM_MINUTE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RISE_MINUTES  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_YELLOW_TARGET = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_WHITE_TARGET  = 3'd5;

	// Alarm modes
	localparam logic [MODE_W-1:0] MODE_WAITING   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ALARMING  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CANCELLED = 2'd2;

	// Input item kinds
	localparam logic KIND_TICK   = 1'b0;
	localparam logic KIND_CANCEL = 1'b1;

endpackage

/* design/sunrise_alarm_dimmer.sv */
// Sunrise alarm dimmer: mode sequencer, ramp arithmetic and stream ports.
//
// Each accepted item is a one-second tick (tuser 0) or a cancel request (tuser 1) and gives
// exactly one result. Cancels and non-ramping ticks pass from the EVAL state through WRITE to
// the output register, and the next item can be taken once the result is loaded. A ramping
// tick in alarming computes yellow then white level as elapsed * target / (rise_minutes * 60)
// on one multiplier and one shared 24-step restoring divider; each channel runs the product,
// the divider start, the 24 steps and done. With a zero ramp length the divider is skipped.
// The block takes no new item until the current one has been written to the output register,
// which may still be waiting on m_tready when the next item is taken. Levels saturate at
// min(LEVEL_MAX, 1023).
module sunrise_alarm_dimmer #(
	parameter int unsigned LEVEL_MAX = sad_pkg::LEVEL_MAX_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_we,
	input  logic [sad_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sad_pkg::CFG_DATA_W-1:0] cfg_wdata,
	// input stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// now_seconds[31:0], hour_of_day[36:32], minute_of_hour[42:37], zero[47:43]
	input  logic [sad_pkg::S_DATA_W-1:0]   s_tdata,
	// kind[0]
	input  logic                           s_tuser,
	// output stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// mode[1:0], alarm_started[2], levels_valid[3], yellow_level[13:4], white_level[23:14]
	output logic [sad_pkg::M_DATA_W-1:0]   m_tdata
);
	import sad_pkg::*;

	localparam logic [LEVEL_W-1:0] LEVEL_SAT =
		(LEVEL_MAX < FIELD_MAX) ? LEVEL_W'(LEVEL_MAX) : LEVEL_W'(FIELD_MAX);

	// Sequencer states
	localparam int unsigned ST_W = 3;
	localparam logic [ST_W-1:0] ST_IDLE   = 3'd0;
	localparam logic [ST_W-1:0] ST_EVAL   = 3'd1;
	localparam logic [ST_W-1:0] ST_MUL    = 3'd2;
	localparam logic [ST_W-1:0] ST_DIV_GO = 3'd3;
	localparam logic [ST_W-1:0] ST_DIV_WT = 3'd4;
	localparam logic [ST_W-1:0] ST_WRITE  = 3'd5;

	// Configuration registers
	logic               enabled_q;
	logic [HOUR_W-1:0]  alarm_hour_q;
	logic [MIN_W-1:0]   alarm_minute_q;
	logic [RISE_W-1:0]  rise_q;
	logic [LEVEL_W-1:0] yellow_tgt_q;
	logic [LEVEL_W-1:0] white_tgt_q;

	// Alarm state
	logic [MODE_W-1:0]  mode_q;
	logic [NOW_W-1:0]   start_q;
	logic [NOW_W-1:0]   end_q;

	// Captured item
	logic               kind_q;
	logic [NOW_W-1:0]   now_q;
	logic [HOUR_W-1:0]  hour_q;
	logic [MIN_W-1:0]   minute_q;

	// Work registers
	logic [ST_W-1:0]    state_q;
	logic               chan_q;
	logic [SPAN_W-1:0]  elapsed_q;
	logic [PROD_W-1:0]  prod_q;
	logic               started_q;
	logic               valid_q;
	logic [LEVEL_W-1:0] ylev_q;
	logic [LEVEL_W-1:0] wlev_q;

	// Output register
	logic                m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;

	// Combinational helpers
	logic               match;
	logic [SPAN_W-1:0]  span;
	logic               span_zero;
	logic [NOW_W:0]     end_sum;
	logic [NOW_W-1:0]   end_sat;
	logic [NOW_W-1:0]   elapsed_full;
	logic [LEVEL_W-1:0] tgt_sel;
	logic [PROD_W-1:0]  lvl_raw;
	logic [LEVEL_W-1:0] lvl_sat;
	logic               div_start;
	logic               div_done;
	logic [PROD_W-1:0]  div_quo;
	logic               in_xfer;
	logic               out_load;

	assign in_xfer   = s_tvalid && s_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign match     = (hour_q == alarm_hour_q) && (minute_q == alarm_minute_q);
	assign span      = SPAN_W'(rise_q) * SPAN_W'(SECS_PER_MIN);
	assign span_zero = (rise_q == '0);
	assign out_load  = (state_q == ST_WRITE) && (!m_tvalid_q || m_tready);

	// Ramp end, saturating at the top of the seconds range
	assign end_sum = {1'b0, now_q} + {{(NOW_W+1-SPAN_W){1'b0}}, span};
	assign end_sat = end_sum[NOW_W] ? '1 : end_sum[NOW_W-1:0];

	// Elapsed never exceeds the span fixed at alarm start
	assign elapsed_full = now_q - start_q;

	// Level select and saturation, shared by both channels
	assign tgt_sel   = chan_q ? white_tgt_q : yellow_tgt_q;
	assign lvl_raw   = span_zero ? PROD_W'(tgt_sel) : div_quo;
	assign lvl_sat   = (lvl_raw > PROD_W'(LEVEL_SAT)) ? LEVEL_SAT : lvl_raw[LEVEL_W-1:0];
	assign div_start = (state_q == ST_DIV_GO);

	sad_div #(
		.DVD_W (PROD_W),
		.DVS_W (SPAN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (span),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q      <= 1'b0;
			alarm_hour_q   <= HOUR_W'(7);
			alarm_minute_q <= '0;
			rise_q         <= RISE_W'(15);
			yellow_tgt_q   <= LEVEL_W'(255);
			white_tgt_q    <= LEVEL_W'(255);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ALARM_ENABLED: enabled_q      <= cfg_wdata[0];
				CFG_ALARM_HOUR:    alarm_hour_q   <= cfg_wdata[HOUR_W-1:0];
				CFG_ALARM_MINUTE:  alarm_minute_q <= cfg_wdata[MIN_W-1:0];
				CFG_RISE_MINUTES:  rise_q         <= cfg_wdata[RISE_W-1:0];
				CFG_YELLOW_TARGET: yellow_tgt_q   <= cfg_wdata[LEVEL_W-1:0];
				CFG_WHITE_TARGET:  white_tgt_q    <= cfg_wdata[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	// Item capture
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kind_q   <= s_tuser;
			now_q    <= s_tdata[NOW_W-1:0];
			hour_q   <= s_tdata[NOW_W+HOUR_W-1:NOW_W];
			minute_q <= s_tdata[NOW_W+HOUR_W+MIN_W-1:NOW_W+HOUR_W];
		end
	end

	// Product of elapsed time and target, registered ahead of the divider
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			prod_q <= PROD_W'(elapsed_q) * PROD_W'(tgt_sel);
		end
	end

	// Sequencer and alarm state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mode_q     <= MODE_WAITING;
			start_q    <= '0;
			end_q      <= '0;
			chan_q     <= 1'b0;
			elapsed_q  <= '0;
			started_q  <= 1'b0;
			valid_q    <= 1'b0;
			ylev_q     <= '0;
			wlev_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					ylev_q <= '0;
					wlev_q <= '0;
					chan_q <= 1'b0;
					if (kind_q == KIND_CANCEL) begin
						started_q <= 1'b0;
						valid_q   <= 1'b0;
						state_q   <= ST_WRITE;
						if (mode_q == MODE_ALARMING) begin
							mode_q <= MODE_CANCELLED;
						end
					end else begin
						unique case (mode_q)
							MODE_ALARMING: begin
								started_q <= 1'b0;
								if (now_q > end_q) begin
									mode_q  <= MODE_WAITING;
									valid_q <= 1'b0;
									state_q <= ST_WRITE;
								end else begin
									elapsed_q <= (now_q >= start_q) ?
										elapsed_full[SPAN_W-1:0] : '0;
									valid_q   <= 1'b1;
									state_q   <= ST_MUL;
								end
							end
							MODE_CANCELLED: begin
								started_q <= 1'b0;
								valid_q   <= 1'b0;
								state_q   <= ST_WRITE;
								if (!match) begin
									mode_q <= MODE_WAITING;
								end
							end
							default: begin
								// waiting, and the unused code
								valid_q <= 1'b0;
								state_q <= ST_WRITE;
								if (enabled_q && match) begin
									mode_q    <= MODE_ALARMING;
									start_q   <= now_q;
									end_q     <= end_sat;
									started_q <= 1'b1;
								end else begin
									mode_q    <= MODE_WAITING;
									started_q <= 1'b0;
								end
							end
						endcase
					end
				end
				ST_MUL: begin
					if (span_zero) begin
						// zero rise time: level is the target itself
						if (chan_q) begin
							wlev_q  <= lvl_sat;
							state_q <= ST_WRITE;
						end else begin
							ylev_q  <= lvl_sat;
							chan_q  <= 1'b1;
						end
					end else begin
						state_q <= ST_DIV_GO;
					end
				end
				ST_DIV_GO: begin
					state_q <= ST_DIV_WT;
				end
				ST_DIV_WT: begin
					if (div_done) begin
						if (chan_q) begin
							wlev_q  <= lvl_sat;
							state_q <= ST_WRITE;
						end else begin
							ylev_q  <= lvl_sat;
							chan_q  <= 1'b1;
							state_q <= ST_MUL;
						end
					end
				end
				ST_WRITE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register: loads the finished result, clears once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
			m_tdata_q  <= {wlev_q, ylev_q, valid_q, started_q, mode_q};
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

/* design/sad_div.sv */
// Restoring divider, one quotient bit per cycle.
module sad_div #(
	parameter int unsigned DVD_W = sad_pkg::PROD_W,
	parameter int unsigned DVS_W = sad_pkg::SPAN_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);
	localparam int unsigned CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W:0]   rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] dvs_q;

	logic [DVS_W:0]   rem_shift;
	logic [DVS_W+1:0] rem_diff;

	// Shift in next dividend bit and trial-subtract the divisor
	assign rem_shift = {rem_q[DVS_W-1:0], quo_q[DVD_W-1]};
	assign rem_diff  = {1'b0, rem_shift} - {2'b00, dvs_q};

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CNT_LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!rem_diff[DVS_W+1]) begin
				rem_q <= rem_diff[DVS_W:0];
				quo_q <= {quo_q[DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_shift;
				quo_q <= {quo_q[DVD_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* design/sad_checker.sv */
// Port-level checks for the sunrise alarm dimmer, bound to the top level.
module sad_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [sad_pkg::M_DATA_W-1:0]   m_tdata
);
	import sad_pkg::*;

	// A result held back by the sink stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// One item at a time: no transfer in the cycle after one
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while busy");

	// Mode code three never leaves the block
	a_mode_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] == MODE_WAITING || m_tdata[1:0] == MODE_ALARMING ||
			m_tdata[1:0] == MODE_CANCELLED))
		else $error("illegal mode code");

	// Levels only come while alarming, and never on the firing step
	a_levels_mode: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> m_tdata[1:0] == MODE_ALARMING && !m_tdata[2])
		else $error("levels outside a ramp");

	// Firing step lands in alarming
	a_start_mode: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> m_tdata[1:0] == MODE_ALARMING)
		else $error("start without alarming");

endmodule

bind sunrise_alarm_dimmer sad_checker u_sad_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
